/* src/wgg_pkg.sv */
// ----------------------------------------------------------------------------
// wgg_pkg: shared types and tables of the go-to-goal controller
// Register map, controller/datapath command and status, CORDIC and tanh tables.
// ----------------------------------------------------------------------------
`default_nettype none
package wgg_pkg;

  localparam int RootSteps   = 17;
  localparam int CordicSteps = 15;
  localparam int CntW        = 5;
  localparam logic [17:0] PiQ16 = 18'd205887;

  typedef enum logic [2:0] {
    REG_ANGULAR_GAIN  = 3'd0,
    REG_DISTANCE_GAIN = 3'd1,
    REG_INTEGRAL_GAIN = 3'd2,
    REG_MAX_LINEAR    = 3'd3,
    REG_MAX_ANGULAR   = 3'd4,
    REG_ARRIVE_THRESH = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] angular_gain;
    logic [15:0] distance_gain;
    logic [15:0] integral_gain;
    logic [14:0] max_linear_speed;
    logic [14:0] max_angular_speed;
    logic [15:0] arrive_threshold;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic sq1;
    logic sq2;
    logic root_step;
    logic cordic_init;
    logic cordic_step;
    logic mul1;
    logic mul2;
    logic mul3;
    logic mul4;
    logic mul5;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic root_last;
    logic cordic_last;
    logic arrived;
    logic out_busy;
  } dp_stat_t;

  function automatic logic [15:0] atan_lut(input logic [3:0] i);
    logic [15:0] r;
    unique case (i)
      4'd0:    r = 16'd8192;
      4'd1:    r = 16'd4836;
      4'd2:    r = 16'd2555;
      4'd3:    r = 16'd1297;
      4'd4:    r = 16'd651;
      4'd5:    r = 16'd326;
      4'd6:    r = 16'd163;
      4'd7:    r = 16'd81;
      4'd8:    r = 16'd41;
      4'd9:    r = 16'd20;
      4'd10:   r = 16'd10;
      4'd11:   r = 16'd5;
      4'd12:   r = 16'd3;
      4'd13:   r = 16'd1;
      4'd14:   r = 16'd1;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] tanh_lut(input logic [4:0] i);
    logic [15:0] r;
    unique case (i)
      5'd0:    r = 16'd0;
      5'd1:    r = 16'd8025;
      5'd2:    r = 16'd15143;
      5'd3:    r = 16'd20813;
      5'd4:    r = 16'd24956;
      5'd5:    r = 16'd27797;
      5'd6:    r = 16'd29660;
      5'd7:    r = 16'd30847;
      5'd8:    r = 16'd31589;
      5'd9:    r = 16'd32048;
      5'd10:   r = 16'd32329;
      5'd11:   r = 16'd32501;
      5'd12:   r = 16'd32606;
      5'd13:   r = 16'd32670;
      5'd14:   r = 16'd32708;
      5'd15:   r = 16'd32732;
      5'd16:   r = 16'd32746;
      default: r = 16'd32768;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/waypoint_go_to_goal_controller.sv */
// ----------------------------------------------------------------------------
// waypoint_go_to_goal_controller: differential-drive go-to-goal PI controller
// Distance and bearing to a waypoint, clamped turn rate, tanh forward speed.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | target_x target_y pos_x pos_y heading clear_integral
//  out     | out_valid / out_ready| linear_velocity turn_rate arrived
//  cfg     | apb psel/penable     | paddr pwdata prdata (6 registers at 4*i)
//
//  a request runs from accept to result register through the 17-step root and,
//  unless the waypoint is reached, the 15-step cordic and the gain products
//  one request is in flight at a time; in_ready is high only while idle
//  the result register lets the next request enter while a result waits
//  reset restores register defaults and zeroes the distance integral
//  a stalled output holds the sequencer in its final step until taken
`default_nettype none
module waypoint_go_to_goal_controller
  import wgg_pkg::*;
(
  input  wire  logic               clk,
  input  wire  logic               rst,
  // apb configuration
  input  wire  logic               psel,
  input  wire  logic               penable,
  input  wire  logic               pwrite,
  input  wire  logic [4:0]         paddr,
  input  wire  logic [31:0]        pwdata,
  output       logic [31:0]        prdata,
  output       logic               pready,
  // request channel
  input  wire  logic               in_valid,
  output       logic               in_ready,
  input  wire  logic signed [15:0] target_x,
  input  wire  logic signed [15:0] target_y,
  input  wire  logic signed [15:0] pos_x,
  input  wire  logic signed [15:0] pos_y,
  input  wire  logic signed [15:0] heading,
  input  wire  logic               clear_integral,
  // result channel
  output       logic               out_valid,
  input  wire  logic               out_ready,
  output       logic signed [15:0] linear_velocity,
  output       logic signed [15:0] turn_rate,
  output       logic               arrived
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;

  // register writes keep the low bits of each register's width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angular_gain      <= 16'd256;
      cfg.distance_gain     <= 16'd256;
      cfg.integral_gain     <= 16'd0;
      cfg.max_linear_speed  <= 15'd0;
      cfg.max_angular_speed <= 15'd1024;
      cfg.arrive_threshold  <= 16'd205;
    end else if (wr_en) begin
      unique case (idx)
        REG_ANGULAR_GAIN:  cfg.angular_gain      <= pwdata[15:0];
        REG_DISTANCE_GAIN: cfg.distance_gain     <= pwdata[15:0];
        REG_INTEGRAL_GAIN: cfg.integral_gain     <= pwdata[15:0];
        REG_MAX_LINEAR:    cfg.max_linear_speed  <= pwdata[14:0];
        REG_MAX_ANGULAR:   cfg.max_angular_speed <= pwdata[14:0];
        REG_ARRIVE_THRESH: cfg.arrive_threshold  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register readback, unmapped addresses read zero
  always_comb begin
    unique case (idx)
      REG_ANGULAR_GAIN:  prdata = {16'd0, cfg.angular_gain};
      REG_DISTANCE_GAIN: prdata = {16'd0, cfg.distance_gain};
      REG_INTEGRAL_GAIN: prdata = {16'd0, cfg.integral_gain};
      REG_MAX_LINEAR:    prdata = {17'd0, cfg.max_linear_speed};
      REG_MAX_ANGULAR:   prdata = {17'd0, cfg.max_angular_speed};
      REG_ARRIVE_THRESH: prdata = {16'd0, cfg.arrive_threshold};
      default:           prdata = '0;
    endcase
  end

  // sequencer
  wgg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // arithmetic and result register
  wgg_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg             (cfg),
    .target_x        (target_x),
    .target_y        (target_y),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .heading         (heading),
    .clear_integral  (clear_integral),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .linear_velocity (linear_velocity),
    .turn_rate       (turn_rate),
    .arrived         (arrived)
  );

  // arrival forces both commands to zero
  a_arrived_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && arrived |-> linear_velocity == 16'sd0 && turn_rate == 16'sd0)
    else $error("arrived result with nonzero command");

  // forward speed is never negative
  a_linear_nonneg : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !linear_velocity[15])
    else $error("negative linear velocity");

  // turn rate within the configured clamp
  a_angular_clamp : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $signed(turn_rate) <= $signed({1'b0, cfg.max_angular_speed})
               && $signed(turn_rate) >= -$signed({1'b0, cfg.max_angular_speed}))
    else $error("turn rate outside clamp");

  // a new request is only taken while no result is being formed
  a_single_request : assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

endmodule
`default_nettype wire

/* src/wgg_dp.sv */
// ----------------------------------------------------------------------------
// wgg_dp: datapath of the go-to-goal controller
// Squares, digit-serial root, CORDIC vectoring, gain products, tanh, integral.
// ----------------------------------------------------------------------------
`default_nettype none
module wgg_dp
  import wgg_pkg::*;
(
  input  wire  logic               clk,
  input  wire  logic               rst,
  input  wire  dp_cmd_t            cmd,
  output       dp_stat_t           stat,
  input  wire  cfg_t               cfg,
  input  wire  logic signed [15:0] target_x,
  input  wire  logic signed [15:0] target_y,
  input  wire  logic signed [15:0] pos_x,
  input  wire  logic signed [15:0] pos_y,
  input  wire  logic signed [15:0] heading,
  input  wire  logic               clear_integral,
  output       logic               out_valid,
  input  wire  logic               out_ready,
  output       logic signed [15:0] linear_velocity,
  output       logic signed [15:0] turn_rate,
  output       logic               arrived
);

  logic signed [16:0] dx, dy;
  logic        [15:0] hdg;
  logic        [31:0] distance_sum;
  logic        [33:0] nsq;
  logic        [33:0] rem;
  logic        [34:0] root;
  logic        [33:0] rbit;
  logic [CntW-1:0]    cnt;
  logic signed [27:0] cx, cy;
  logic        [15:0] cz;
  logic               arr_flag;
  logic signed [32:0] ge;
  logic        [32:0] pdg;
  logic        [47:0] pig;
  logic signed [51:0] wp;
  logic        [48:0] u;
  logic signed [15:0] w_reg;
  logic        [15:0] t_base;
  logic        [31:0] t_prod;
  logic               t_big;
  logic        [15:0] th;
  logic        [15:0] v_reg;

  logic        [34:0] trial;
  logic        [16:0] d;
  logic signed [27:0] xs, ys, x0;
  logic signed [15:0] e;
  logic signed [51:0] wr_full;
  logic signed [22:0] wr;
  logic signed [22:0] lim;
  logic        [4:0]  ti;
  logic        [15:0] t_next;
  logic        [15:0] t_diff;
  logic        [30:0] vprod;
  logic        [32:0] sum_ext;
  logic        [16:0] t_add;

  assign trial   = root + {1'b0, rbit};
  assign d       = root[16:0];
  assign xs      = cx >>> cnt[3:0];
  assign ys      = cy >>> cnt[3:0];
  assign x0      = 28'(dx) <<< 8;
  assign e       = $signed(cz - hdg);
  assign wr_full = (wp + 52'sd268435456) >>> 29;
  assign wr      = wr_full[22:0];
  assign lim     = $signed({8'd0, cfg.max_angular_speed});
  assign ti      = {1'b0, u[19:16]};
  assign t_next  = tanh_lut(ti + 5'd1);
  assign t_diff  = t_next - tanh_lut(ti);
  assign vprod   = cfg.max_linear_speed * th;
  assign sum_ext = {1'b0, distance_sum} + {16'd0, d};
  assign t_add   = {1'b0, t_prod[31:16]} + {16'd0, t_prod[15]};

  assign stat.root_last   = (cnt == CntW'(RootSteps - 1));
  assign stat.cordic_last = (cnt == CntW'(CordicSteps - 1));
  assign stat.arrived     = ({1'b0, cfg.arrive_threshold} >= d);
  assign stat.out_busy    = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_sum <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.load && clear_integral) begin
        distance_sum <= '0;
      end else if (cmd.mul5) begin
        distance_sum <= sum_ext[32] ? 32'hFFFF_FFFF : sum_ext[31:0];
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx  <= 17'(target_x) - 17'(pos_x);
      dy  <= 17'(target_y) - 17'(pos_y);
      hdg <= heading;
    end
    if (cmd.sq1) begin
      nsq <= 34'(dx * dx);
    end
    if (cmd.sq2) begin
      rem  <= nsq + 34'(dy * dy);
      root <= '0;
      rbit <= 34'd1 << 32;
    end
    if (cmd.root_step) begin
      if ({1'b0, rem} >= trial) begin
        rem  <= rem - trial[33:0];
        root <= (root >> 1) + {1'b0, rbit};
      end else begin
        root <= root >> 1;
      end
      rbit <= rbit >> 2;
    end
    if (cmd.sq2 || cmd.cordic_init) begin
      cnt <= '0;
    end else if (cmd.root_step || cmd.cordic_step) begin
      cnt <= cnt + 1'b1;
    end
    if (cmd.cordic_init) begin
      arr_flag <= stat.arrived;
      if (dx[16]) begin
        cx <= -x0;
        cy <= -(28'(dy) <<< 8);
        cz <= 16'h8000;
      end else begin
        cx <= x0;
        cy <= 28'(dy) <<< 8;
        cz <= '0;
      end
    end
    if (cmd.cordic_step) begin
      if (!cy[27]) begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + atan_lut(cnt[3:0]);
      end else begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - atan_lut(cnt[3:0]);
      end
    end
    if (cmd.mul1) begin
      ge  <= $signed({1'b0, cfg.angular_gain}) * e;
      pdg <= cfg.distance_gain * d;
      pig <= cfg.integral_gain * distance_sum;
    end
    if (cmd.mul2) begin
      wp <= ge * $signed({1'b0, PiQ16});
      u  <= {16'd0, pdg} + {1'b0, pig};
    end
    if (cmd.mul3) begin
      if (wr > lim) begin
        w_reg <= lim[15:0];
      end else if (wr < -lim) begin
        w_reg <= 16'(-lim);
      end else begin
        w_reg <= wr[15:0];
      end
      t_big  <= |u[48:20];
      t_base <= tanh_lut(ti);
      t_prod <= t_diff * u[15:0];
    end
    if (cmd.mul4) begin
      th <= t_big ? 16'h8000 : t_base + t_add[15:0];
    end
    if (cmd.mul5) begin
      v_reg <= 16'(({1'b0, vprod} + 32'd16384) >> 15);
    end
    if (cmd.emit) begin
      arrived         <= arr_flag;
      linear_velocity <= arr_flag ? '0 : $signed(v_reg);
      turn_rate       <= arr_flag ? '0 : w_reg;
    end
  end

endmodule
`default_nettype wire

/* src/wgg_ctrl.sv */
// ----------------------------------------------------------------------------
// wgg_ctrl: sequencer of the go-to-goal controller
// Steps the datapath through squares, root and, unless arrived, CORDIC and the gain products.
// ----------------------------------------------------------------------------
`default_nettype none
module wgg_ctrl
  import wgg_pkg::*;
(
  input  wire  logic     clk,
  input  wire  logic     rst,
  input  wire  logic     in_valid,
  output       logic     in_ready,
  output       dp_cmd_t  cmd,
  input  wire  dp_stat_t stat
);

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_SQ1  = 12'b0000_0000_0010,
    S_SQ2  = 12'b0000_0000_0100,
    S_ROOT = 12'b0000_0000_1000,
    S_CMP  = 12'b0000_0001_0000,
    S_CORD = 12'b0000_0010_0000,
    S_MUL1 = 12'b0000_0100_0000,
    S_MUL2 = 12'b0000_1000_0000,
    S_MUL3 = 12'b0001_0000_0000,
    S_MUL4 = 12'b0010_0000_0000,
    S_MUL5 = 12'b0100_0000_0000,
    S_FIN  = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SQ1;
        end
      end
      S_SQ1: begin
        cmd.sq1    = 1'b1;
        state_next = S_SQ2;
      end
      S_SQ2: begin
        cmd.sq2    = 1'b1;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (stat.root_last) state_next = S_CMP;
      end
      S_CMP: begin
        cmd.cordic_init = 1'b1;
        state_next      = stat.arrived ? S_FIN : S_CORD;
      end
      S_CORD: begin
        cmd.cordic_step = 1'b1;
        if (stat.cordic_last) state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul3   = 1'b1;
        state_next = S_MUL4;
      end
      S_MUL4: begin
        cmd.mul4   = 1'b1;
        state_next = S_MUL5;
      end
      S_MUL5: begin
        cmd.mul5   = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire
